[src/fbcm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbcm_pkg
// Shared types and codes of the block chain manager: field widths, command
// codes, status codes, register map and the table request/response structs.
// ----------------------------------------------------------------------------
package fbcm_pkg;

    localparam int CMD_W   = 2;
    localparam int BLK_W   = 10;
    localparam int CNT_W   = 7;
    localparam int FREED_W = 11;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [CMD_W-1:0] CMD_ALLOC      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE_CHAIN = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FREE_ONE   = 2'd3;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // register index is the upper address bit, byte offset below it
    localparam logic REG_FIRST_DATA = 1'b0;

    localparam logic [BLK_W-1:0] FIRST_DATA_RESET = 10'd10;

    typedef struct packed {
        logic rd_en;
        logic we_used;
        logic we_link;
        logic wd_used;
    } fbcm_req_t;

    typedef struct packed {
        logic valid;
        logic used;
    } fbcm_rsp_t;

endpackage

[src/fbcm_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbcm_table
// Allocation table storage: used flags and link pointers in two synchronous
// memories with one write port and one read port; read data is registered.
// A read of the entry written in the same cycle returns the new value.
// ----------------------------------------------------------------------------
module fbcm_table #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int PW    = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fbcm_pkg::fbcm_req_t req,
    input  logic [AW-1:0]       rd_addr,
    input  logic [AW-1:0]       wr_addr,
    input  logic [PW-1:0]       wd_link,
    output fbcm_pkg::fbcm_rsp_t rsp,
    output logic [AW-1:0]       rd_tag,
    output logic [PW-1:0]       rd_link
);
    import fbcm_pkg::*;

    logic          used_mem [DEPTH];
    logic [PW-1:0] link_mem [DEPTH];

    logic          rd_used_reg;
    logic [PW-1:0] rd_link_reg;
    logic [AW-1:0] rd_tag_reg;
    logic          rd_valid_reg;
    logic          fwd_used_hit_reg;
    logic          fwd_link_hit_reg;
    logic          fwd_used_reg;
    logic [PW-1:0] fwd_link_reg;

    logic fwd_used_hit_next;
    logic fwd_link_hit_next;

    assign fwd_used_hit_next = req.rd_en && req.we_used && (rd_addr == wr_addr);
    assign fwd_link_hit_next = req.rd_en && req.we_link && (rd_addr == wr_addr);

    always_ff @(posedge clk)
    begin
        if (req.we_used)
        begin
            used_mem[wr_addr] <= req.wd_used;
        end
        if (req.we_link)
        begin
            link_mem[wr_addr] <= wd_link;
        end
        if (req.rd_en)
        begin
            rd_used_reg  <= used_mem[rd_addr];
            rd_link_reg  <= link_mem[rd_addr];
            rd_tag_reg   <= rd_addr;
            fwd_used_reg <= req.wd_used;
            fwd_link_reg <= wd_link;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg     <= 1'b0;
            fwd_used_hit_reg <= 1'b0;
            fwd_link_hit_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg     <= req.rd_en;
            fwd_used_hit_reg <= fwd_used_hit_next;
            fwd_link_hit_reg <= fwd_link_hit_next;
        end
    end

    assign rsp.valid = rd_valid_reg;
    assign rsp.used  = fwd_used_hit_reg ? fwd_used_reg : rd_used_reg;
    assign rd_link   = fwd_link_hit_reg ? fwd_link_reg : rd_link_reg;
    assign rd_tag    = rd_tag_reg;

endmodule

[src/fat_block_chain_manager.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_block_chain_manager
// Block allocation table manager: allocate, append, free chain, free block.
//
// Commands arrive on cmd_valid/cmd_stall with command, start_block and
// block_count; results leave on res_valid/res_stall with block, status,
// freed_count and last. An append gives one word per new block and a status
// word if rejected or full, others one word; last marks a command's final word.
// first_data_block is written over the APB-style port at address 0.
// After reset the table is swept once, one entry a cycle, with cmd_stall
// high; register writes are taken during the sweep.
// One command is in work at a time. Cost is set by the single table read
// port, one entry a cycle:
//   allocate: a scan from first_data_block, then the mark of the block found
//   append:   a walk of the chain, one scan pass, a link and a mark per new block
//   free chain: a walk that clears each entry; free block and rejects: the result
// Result words sit in an output register; while the receiver stalls the
// word holds and the command in work waits at its next result.
// ----------------------------------------------------------------------------
module fat_block_chain_manager #(
    parameter int NUM_BLOCKS = 1024,
    parameter int MAX_APPEND = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fbcm_pkg::APB_AW-1:0]   paddr,
    input  logic [fbcm_pkg::APB_DW-1:0]   pwdata,
    output logic [fbcm_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  logic [fbcm_pkg::CMD_W-1:0]    command,
    input  logic [fbcm_pkg::BLK_W-1:0]    start_block,
    input  logic [fbcm_pkg::CNT_W-1:0]    block_count,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [fbcm_pkg::BLK_W-1:0]    block,
    output logic                          status,
    output logic [fbcm_pkg::FREED_W-1:0]  freed_count,
    output logic                          last
);
    import fbcm_pkg::*;

    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int PW = AW + 1;
    localparam int SW = AW + 1;
    localparam logic [PW-1:0]    LINK_END  = '1;
    localparam logic [SW-1:0]    NUM_S     = SW'(NUM_BLOCKS);
    localparam logic [SW-1:0]    STEP_LAST = SW'(NUM_BLOCKS - 1);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(NUM_BLOCKS - 1);
    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_APPEND);
    localparam logic [31:0]      NUM_W     = 32'(NUM_BLOCKS);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RESP = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_LINK = 3'd5;
    localparam logic [2:0] S_MARK = 3'd6;
    localparam logic [2:0] S_FREE = 3'd7;

    logic [2:0]         state_reg,  state_next;
    logic [SW-1:0]      scan_reg,   scan_next;
    logic [SW-1:0]      steps_reg,  steps_next;
    logic [AW-1:0]      tail_reg,   tail_next;
    logic [AW-1:0]      found_reg,  found_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic [CNT_W-1:0]   k_reg,      k_next;
    logic [CMD_W-1:0]   cmd_reg,    cmd_next;
    logic [BLK_W-1:0]   start_reg,  start_next;
    logic [BLK_W-1:0]   fdb_reg;
    logic [BLK_W-1:0]   pend_block_reg,  pend_block_next;
    logic               pend_status_reg, pend_status_next;
    logic [FREED_W-1:0] pend_freed_reg,  pend_freed_next;
    logic               out_valid_reg;
    logic [BLK_W-1:0]   out_block_reg;
    logic               out_status_reg;
    logic [FREED_W-1:0] out_freed_reg;
    logic               out_last_reg;

    fbcm_req_t    req;
    fbcm_rsp_t    rsp;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [PW-1:0] wd_link;
    logic [AW-1:0] rd_tag;
    logic [PW-1:0] rd_link;

    logic               out_load;
    logic [BLK_W-1:0]   load_block;
    logic               load_status;
    logic [FREED_W-1:0] load_freed;
    logic               load_last;
    logic               can_emit;
    logic               start_oob;
    logic               fdb_oob;
    logic               link_end;
    logic [CNT_W-1:0]   sat_cnt;
    logic               cfg_write;

    fbcm_table #(
        .DEPTH (NUM_BLOCKS),
        .AW    (AW),
        .PW    (PW)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wd_link (wd_link),
        .rsp     (rsp),
        .rd_tag  (rd_tag),
        .rd_link (rd_link)
    );

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[APB_AW-1] == REG_FIRST_DATA);
    assign prdata    = (paddr[APB_AW-1] == REG_FIRST_DATA) ? APB_DW'(fdb_reg) : '0;

    assign can_emit  = !out_valid_reg || !res_stall;
    assign start_oob = (32'(start_block) >= NUM_W);
    assign fdb_oob   = (32'(fdb_reg) >= NUM_W);
    assign link_end  = (rd_link >= NUM_S);
    assign sat_cnt   = (block_count > MAX_CNT) ? MAX_CNT : block_count;
    assign cmd_stall = (state_reg != S_IDLE);

    always_comb
    begin
        logic          go_scan;
        logic          scan_oob;
        logic [SW-1:0] scan_from;

        state_next       = state_reg;
        scan_next        = scan_reg;
        steps_next       = steps_reg;
        tail_next        = tail_reg;
        found_next       = found_reg;
        cnt_next         = cnt_reg;
        k_next           = k_reg;
        cmd_next         = cmd_reg;
        start_next       = start_reg;
        pend_block_next  = pend_block_reg;
        pend_status_next = pend_status_reg;
        pend_freed_next  = pend_freed_reg;
        req              = '0;
        rd_addr          = '0;
        wr_addr          = '0;
        wd_link          = LINK_END;
        out_load         = 1'b0;
        load_block       = '0;
        load_status      = STATUS_OK;
        load_freed       = '0;
        load_last        = 1'b1;
        go_scan          = 1'b0;
        scan_oob         = 1'b0;
        scan_from        = '0;

        unique case (state_reg)
            S_INIT:
            begin
                req.we_used = 1'b1;
                req.wd_used = 1'b0;
                req.we_link = 1'b1;
                wr_addr     = scan_reg[AW-1:0];
                scan_next   = scan_reg + SW'(1);
                if (scan_reg[AW-1:0] == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next         = command;
                    start_next       = start_block;
                    cnt_next         = sat_cnt;
                    k_next           = '0;
                    steps_next       = '0;
                    pend_block_next  = start_block;
                    pend_status_next = STATUS_OK;
                    pend_freed_next  = '0;
                    unique case (command)
                        CMD_ALLOC:
                        begin
                            go_scan   = 1'b1;
                            scan_oob  = fdb_oob;
                            scan_from = SW'(fdb_reg);
                        end
                        CMD_APPEND:
                        begin
                            if (start_oob || (sat_cnt == '0))
                            begin
                                state_next = S_RESP;
                            end
                            else
                            begin
                                req.rd_en  = 1'b1;
                                rd_addr    = AW'(start_block);
                                state_next = S_WALK;
                            end
                        end
                        CMD_FREE_CHAIN:
                        begin
                            if (start_oob)
                            begin
                                state_next = S_RESP;
                            end
                            else
                            begin
                                req.rd_en  = 1'b1;
                                rd_addr    = AW'(start_block);
                                state_next = S_FREE;
                            end
                        end
                        CMD_FREE_ONE:
                        begin
                            if (!start_oob)
                            begin
                                req.we_used = 1'b1;
                                req.wd_used = 1'b0;
                                req.we_link = 1'b1;
                                wr_addr     = AW'(start_block);
                            end
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_RESP:
            begin
                if (can_emit)
                begin
                    out_load    = 1'b1;
                    load_block  = pend_block_reg;
                    load_status = pend_status_reg;
                    load_freed  = pend_freed_reg;
                    load_last   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (rsp.valid)
                begin
                    if (link_end)
                    begin
                        tail_next = rd_tag;
                        go_scan   = 1'b1;
                        scan_oob  = fdb_oob;
                        scan_from = SW'(fdb_reg);
                    end
                    else if (steps_reg == STEP_LAST)
                    begin
                        // walk bound reached: the last link read is the tail
                        tail_next = rd_link[AW-1:0];
                        go_scan   = 1'b1;
                        scan_oob  = fdb_oob;
                        scan_from = SW'(fdb_reg);
                    end
                    else
                    begin
                        req.rd_en  = 1'b1;
                        rd_addr    = rd_link[AW-1:0];
                        steps_next = steps_reg + SW'(1);
                    end
                end
            end
            S_SCAN:
            begin
                if (rsp.valid && !rsp.used)
                begin
                    found_next = rd_tag;
                    state_next = (cmd_reg == CMD_APPEND) ? S_LINK : S_MARK;
                end
                else if (rsp.valid && (rd_tag == LAST_ADDR))
                begin
                    pend_block_next  = start_reg;
                    pend_status_next = STATUS_FULL;
                    pend_freed_next  = '0;
                    state_next       = S_RESP;
                end
                else if (scan_reg < NUM_S)
                begin
                    req.rd_en = 1'b1;
                    rd_addr   = scan_reg[AW-1:0];
                    scan_next = scan_reg + SW'(1);
                end
            end
            S_LINK:
            begin
                req.we_link = 1'b1;
                wr_addr     = tail_reg;
                wd_link     = PW'(found_reg);
                state_next  = S_MARK;
            end
            S_MARK:
            begin
                if (can_emit)
                begin
                    req.we_used = 1'b1;
                    req.wd_used = 1'b1;
                    req.we_link = 1'b1;
                    wr_addr     = found_reg;
                    out_load    = 1'b1;
                    load_block  = BLK_W'(found_reg);
                    load_status = STATUS_OK;
                    load_freed  = '0;
                    load_last   = (cmd_reg != CMD_APPEND) || ((k_reg + CNT_W'(1)) == cnt_reg);
                    if (load_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // blocks from first_data_block to the new one are in use: search on past it
                        k_next    = k_reg + CNT_W'(1);
                        tail_next = found_reg;
                        go_scan   = 1'b1;
                        scan_oob  = (found_reg == LAST_ADDR);
                        scan_from = SW'(found_reg) + SW'(1);
                    end
                end
            end
            S_FREE:
            begin
                if (rsp.valid)
                begin
                    req.we_used = 1'b1;
                    req.wd_used = 1'b0;
                    req.we_link = 1'b1;
                    wr_addr     = rd_tag;
                    if (link_end || (steps_reg == STEP_LAST))
                    begin
                        pend_block_next  = start_reg;
                        pend_status_next = STATUS_OK;
                        pend_freed_next  = FREED_W'(steps_reg + SW'(1));
                        state_next       = S_RESP;
                    end
                    else
                    begin
                        req.rd_en  = 1'b1;
                        rd_addr    = rd_link[AW-1:0];
                        steps_next = steps_reg + SW'(1);
                    end
                end
            end
        endcase

        if (go_scan)
        begin
            if (scan_oob)
            begin
                pend_block_next  = start_next;
                pend_status_next = STATUS_FULL;
                pend_freed_next  = '0;
                state_next       = S_RESP;
            end
            else
            begin
                scan_next  = scan_from;
                state_next = S_SCAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            scan_reg      <= '0;
            steps_reg     <= '0;
            k_reg         <= '0;
            cnt_reg       <= '0;
            cmd_reg       <= CMD_ALLOC;
            fdb_reg       <= FIRST_DATA_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            steps_reg <= steps_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
            cmd_reg   <= cmd_next;
            if (cfg_write)
            begin
                fdb_reg <= pwdata[BLK_W-1:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tail_reg        <= tail_next;
        found_reg       <= found_next;
        start_reg       <= start_next;
        pend_block_reg  <= pend_block_next;
        pend_status_reg <= pend_status_next;
        pend_freed_reg  <= pend_freed_next;
        if (out_load)
        begin
            out_block_reg  <= load_block;
            out_status_reg <= load_status;
            out_freed_reg  <= load_freed;
            out_last_reg   <= load_last;
        end
    end

    assign res_valid   = out_valid_reg;
    assign block       = out_block_reg;
    assign status      = out_status_reg;
    assign freed_count = out_freed_reg;
    assign last        = out_last_reg;

    // table writes stay inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.we_used || req.we_link) |-> (32'(wr_addr) < NUM_W))
        else $error("table write beyond last block");

    // a block is marked only after the scan saw it free
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK && $past(state_reg) == S_SCAN)
            |-> $past(rsp.valid && !rsp.used))
        else $error("block marked without a free read");

    // append never gives more words than asked for
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK && cmd_reg == CMD_APPEND) |-> (k_reg < cnt_reg))
        else $error("append word count overrun");

    // no command and no result during the clearing sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT) |-> (cmd_stall && !res_valid))
        else $error("traffic during table sweep");

endmodule

[bench/fat_block_chain_manager_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_block_chain_manager_test
// Self-checking bench for the block chain manager. Commands are fed from a
// queue into a clocked driver; a clocked monitor checks every result word
// against a predicted table of used flags and next pointers. Runs a directed
// set of corner cases, then random chain traffic under several settings of
// the allocation floor, with random idling on both sides and one long
// receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module fat_block_chain_manager_test;

    import fbcm_pkg::*;

    localparam int NUM_BLK        = 1024;
    localparam int MAX_LINK       = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 2200;
    localparam int PRINT_LIMIT    = 100;
    localparam logic [FREED_W-1:0] PTR_END = '1;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [BLK_W-1:0] start;
        logic [CNT_W-1:0] cnt;
    } cmd_word_t;

    typedef struct packed {
        logic [BLK_W-1:0]   blk;
        logic               st;
        logic [FREED_W-1:0] freed;
        logic               lst;
    } result_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    logic                cmd_valid = 1'b0;
    logic                cmd_stall;
    logic [CMD_W-1:0]    command = '0;
    logic [BLK_W-1:0]    start_block = '0;
    logic [CNT_W-1:0]    block_count = '0;

    logic                res_valid;
    logic                res_stall = 1'b0;
    logic [BLK_W-1:0]    block;
    logic                status;
    logic [FREED_W-1:0]  freed_count;
    logic                last;

    // predicted table and floor
    logic [FREED_W-1:0] link_of [NUM_BLK];
    logic               taken [NUM_BLK];
    logic [BLK_W-1:0]   search_floor;

    cmd_word_t    pending_cmds [$];
    result_word_t expected_words [$];
    int           mismatches = 0;
    int           quiet_cycles = 0;

    logic idle_on = 1'b1;
    logic hold_arm = 1'b0;
    logic hold_spent = 1'b0;
    int   hold_left = 0;

    fat_block_chain_manager #(
        .NUM_BLOCKS (NUM_BLK),
        .MAX_APPEND (MAX_LINK)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .command     (command),
        .start_block (start_block),
        .block_count (block_count),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .block       (block),
        .status      (status),
        .freed_count (freed_count),
        .last        (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void clear_table();
        for (int i = 0; i < NUM_BLK; i++)
        begin
            link_of[i] = PTR_END;
            taken[i] = 1'b0;
        end
        search_floor = FIRST_DATA_RESET;
    endfunction

    function automatic int first_free_block();
        for (int i = search_floor; i < NUM_BLK; i++)
        begin
            if (!taken[i])
                return i;
        end
        return -1;
    endfunction

    function automatic void expect_word(int blk, logic st, int freed, logic lst);
        result_word_t r;
        r.blk = blk[BLK_W-1:0];
        r.st = st;
        r.freed = freed[FREED_W-1:0];
        r.lst = lst;
        expected_words.push_back(r);
    endfunction

    // updates the predicted table and queues the words the command gives
    function automatic void apply_command(cmd_word_t w);
        int f;
        int cur;
        int cnt;
        int freed;
        logic [FREED_W-1:0] nx;
        if (w.cmd == CMD_ALLOC)
        begin
            f = first_free_block();
            if (f < 0)
            begin
                expect_word(w.start, STATUS_FULL, 0, 1'b1);
            end
            else
            begin
                taken[f] = 1'b1;
                link_of[f] = PTR_END;
                expect_word(f, STATUS_OK, 0, 1'b1);
            end
        end
        else if (int'(w.start) >= NUM_BLK)
        begin
            expect_word(w.start, STATUS_OK, 0, 1'b1);
        end
        else if (w.cmd == CMD_APPEND)
        begin
            cnt = (w.cnt > MAX_LINK) ? MAX_LINK : int'(w.cnt);
            if (cnt == 0)
            begin
                expect_word(w.start, STATUS_OK, 0, 1'b1);
            end
            else
            begin
                cur = w.start;
                for (int s = 0; s < NUM_BLK; s++)
                begin
                    nx = link_of[cur];
                    if (nx >= NUM_BLK)
                        break;
                    cur = nx;
                end
                for (int k = 0; k < cnt; k++)
                begin
                    f = first_free_block();
                    if (f < 0)
                    begin
                        expect_word(w.start, STATUS_FULL, 0, 1'b1);
                        break;
                    end
                    link_of[cur] = f[FREED_W-1:0];
                    taken[f] = 1'b1;
                    link_of[f] = PTR_END;
                    cur = f;
                    expect_word(f, STATUS_OK, 0, k + 1 == cnt);
                end
            end
        end
        else if (w.cmd == CMD_FREE_CHAIN)
        begin
            cur = w.start;
            freed = 0;
            for (int s = 0; s < NUM_BLK; s++)
            begin
                nx = link_of[cur];
                link_of[cur] = PTR_END;
                taken[cur] = 1'b0;
                freed++;
                if (nx >= NUM_BLK)
                    break;
                cur = nx;
            end
            expect_word(w.start, STATUS_OK, freed, 1'b1);
        end
        else
        begin
            taken[w.start] = 1'b0;
            link_of[w.start] = PTR_END;
            expect_word(w.start, STATUS_OK, 0, 1'b1);
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (mismatches < PRINT_LIMIT)
            $display("%0t mismatch %0s: got %0d want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // command driver
    always @(posedge clk)
    begin
        cmd_word_t w;
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
                apply_command({command, start_block, block_count});
            if (!(cmd_valid && cmd_stall))
            begin
                if (pending_cmds.size() != 0 && (!idle_on || $urandom_range(99) >= 20))
                begin
                    w = pending_cmds.pop_front();
                    command <= w.cmd;
                    start_block <= w.start;
                    block_count <= w.cnt;
                    cmd_valid <= 1'b1;
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, armed once
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_arm && !hold_spent)
        begin
            hold_left <= HOLD_CYCLES;
            hold_spent <= 1'b1;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    report_mismatch("word with nothing expected, block", block, 0);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (block !== want.blk)
                        report_mismatch("block", block, want.blk);
                    if (status !== want.st)
                        report_mismatch("status", status, want.st);
                    if (freed_count !== want.freed)
                        report_mismatch("freed_count", freed_count, want.freed);
                    if (last !== want.lst)
                        report_mismatch("last", last, want.lst);
                end
            end
            res_stall <= (hold_left != 0) || (idle_on && $urandom_range(99) < 20);
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic set_first_data(input logic [BLK_W-1:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_FIRST_DATA, 2'b00};
        pwdata <= APB_DW'(v);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        search_floor = v;
    endtask

    task automatic queue_command(input logic [CMD_W-1:0] c, input int s, input int n);
        cmd_word_t w;
        w.cmd = c;
        w.start = s[BLK_W-1:0];
        w.cnt = n[CNT_W-1:0];
        while (pending_cmds.size() >= 2)
            @(negedge clk);
        pending_cmds.push_back(w);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || cmd_valid || expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic int some_taken_block();
        int base;
        int idx;
        base = $urandom_range(NUM_BLK - 1);
        for (int k = 0; k < NUM_BLK; k++)
        begin
            idx = (base + k) % NUM_BLK;
            if (taken[idx])
                return idx;
        end
        return -1;
    endfunction

    // mostly commands on live chains, with some on random blocks
    task automatic queue_random_command();
        logic [CMD_W-1:0] c;
        int roll;
        int s;
        int n;
        roll = $urandom_range(99);
        if (roll < 30)
            c = CMD_ALLOC;
        else if (roll < 65)
            c = CMD_APPEND;
        else if (roll < 85)
            c = CMD_FREE_CHAIN;
        else
            c = CMD_FREE_ONE;
        s = some_taken_block();
        if (s < 0 || $urandom_range(99) < 15)
            s = $urandom_range(NUM_BLK - 1);
        roll = $urandom_range(99);
        if (roll < 70)
            n = $urandom_range(8, 1);
        else if (roll < 85)
            n = $urandom_range(MAX_LINK, 9);
        else if (roll < 95)
            n = $urandom_range(127, MAX_LINK + 1);
        else
            n = 0;
        queue_command(c, s, n);
    endtask

    initial
    begin
        clear_table();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // only four blocks allocatable: full disk paths
        set_first_data(10'd1020);
        queue_command(CMD_ALLOC, 0, 0);
        queue_command(CMD_APPEND, 1020, 0);
        queue_command(CMD_APPEND, 1020, 1);
        queue_command(CMD_APPEND, 1020, 127);
        queue_command(CMD_ALLOC, 10'h2AA, 0);
        queue_command(CMD_FREE_ONE, 1021, 0);
        queue_command(CMD_FREE_CHAIN, 1020, 0);
        queue_command(CMD_FREE_CHAIN, 0, 0);
        queue_command(CMD_FREE_ONE, 1023, 0);
        queue_command(CMD_FREE_ONE, 5, 0);
        queue_command(CMD_APPEND, 1022, 3);
        queue_command(CMD_FREE_CHAIN, 1022, 0);
        queue_command(CMD_FREE_CHAIN, 1023, 0);
        wait_drained();

        // whole table allocatable: longest append
        set_first_data(10'd0);
        queue_command(CMD_ALLOC, 10'h155, 0);
        queue_command(CMD_APPEND, 0, MAX_LINK);
        queue_command(CMD_APPEND, 0, 2);
        queue_command(CMD_FREE_CHAIN, 0, 0);
        queue_command(CMD_ALLOC, 0, 0);
        queue_command(CMD_APPEND, 0, 127);
        queue_command(CMD_FREE_ONE, 30, 0);
        queue_command(CMD_FREE_CHAIN, 0, 0);
        for (int i = 0; i < 70; i++)
        begin
            if (i == 20)
            begin
                @(posedge clk);
                hold_arm <= 1'b1;
            end
            queue_random_command();
        end
        wait_drained();

        set_first_data(10'd1023);
        for (int i = 0; i < 10; i++)
            queue_random_command();
        wait_drained();

        // no idling on either side
        @(posedge clk);
        idle_on <= 1'b0;
        set_first_data(10'($urandom_range(900, 1)));
        for (int i = 0; i < 60; i++)
            queue_random_command();
        wait_drained();

        @(posedge clk);
        idle_on <= 1'b1;
        set_first_data(FIRST_DATA_RESET);
        for (int i = 0; i < 60; i++)
            queue_random_command();
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatches == 0 && expected_words.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
